// ===== rtl/crfc_pkg.sv =====
package crfc_pkg;

   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;

   localparam logic [7:0] CMD_COLUMN_ADDR = 8'h2A;
   localparam logic [7:0] CMD_ROW_ADDR    = 8'h2B;
   localparam logic [7:0] CMD_MEM_WRITE   = 8'h2C;
   localparam logic [7:0] ADDR_HIGH_BYTE  = 8'h00;

   localparam logic [1:0] CSR_PANEL_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_PANEL_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_COLUMN_OFFSET = 2'd2;
   localparam logic [1:0] CSR_ROW_OFFSET    = 2'd3;

   typedef struct packed {
      logic signed [15:0] origin_x;
      logic signed [15:0] origin_y;
      logic signed [15:0] extent_w;
      logic signed [15:0] extent_h;
      logic [15:0]        fill_color;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [15:0] run_color;
      logic [15:0] run_count;
      logic        last;
   } rsp_type;

   // clipped window, ready to stream
   typedef struct packed {
      logic [7:0]  col_lo;
      logic [7:0]  col_hi;
      logic [7:0]  row_lo;
      logic [7:0]  row_hi;
      logic [7:0]  run_w;
      logic [7:0]  run_h;
      logic [15:0] color;
   } job_type;

endpackage

// ===== rtl/crfc_front.sv =====
module crfc_front #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_start,
   output logic                             req_busy,
   input  crfc_pkg::req_type                req_word,
   input  logic                             csr_write,
   input  logic [1:0]                       csr_index,
   input  logic [7:0]                       csr_data,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
   output logic                             q_push,
   output crfc_pkg::job_type                q_job
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [7:0] panel_w_ff, panel_h_ff, col_off_ff, row_off_ff;

   // clamp stage, config captured with the word
   logic               s1_valid_ff, s1_valid_in;
   logic [15:0]        s1_x_ff, s1_x_in, s1_y_ff, s1_y_in;
   logic signed [16:0] s1_w_ff, s1_w_in, s1_h_ff, s1_h_in;
   logic [15:0]        s1_color_ff;
   logic [7:0]         s1_pw_ff, s1_ph_ff, s1_coff_ff, s1_roff_ff;

   logic               accept;
   logic signed [17:0] x_end, y_end, w_trim, h_trim;
   logic               w_over, h_over;

   assign req_busy = ({1'b0, q_count} + (CW+1)'(s1_valid_ff)) >= (CW+1)'(QUEUE_DEPTH);
   assign accept   = req_start && !req_busy;

   always_comb begin
      s1_valid_in = accept;
      if (req_word.origin_x[15]) begin
         s1_x_in = '0;
         s1_w_in = 17'(req_word.extent_w) + 17'(req_word.origin_x);
      end else begin
         s1_x_in = req_word.origin_x;
         s1_w_in = 17'(req_word.extent_w);
      end
      if (req_word.origin_y[15]) begin
         s1_y_in = '0;
         s1_h_in = 17'(req_word.extent_h) + 17'(req_word.origin_y);
      end else begin
         s1_y_in = req_word.origin_y;
         s1_h_in = 17'(req_word.extent_h);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         panel_w_ff  <= 8'd128;
         panel_h_ff  <= 8'd160;
         col_off_ff  <= 8'd0;
         row_off_ff  <= 8'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (csr_write) begin
            case (csr_index)
               crfc_pkg::CSR_PANEL_WIDTH:   panel_w_ff <= csr_data;
               crfc_pkg::CSR_PANEL_HEIGHT:  panel_h_ff <= csr_data;
               crfc_pkg::CSR_COLUMN_OFFSET: col_off_ff <= csr_data;
               crfc_pkg::CSR_ROW_OFFSET:    row_off_ff <= csr_data;
               default: ;
            endcase
         end
      end
      s1_x_ff     <= s1_x_in;
      s1_y_ff     <= s1_y_in;
      s1_w_ff     <= s1_w_in;
      s1_h_ff     <= s1_h_in;
      s1_color_ff <= req_word.fill_color;
      s1_pw_ff    <= panel_w_ff;
      s1_ph_ff    <= panel_h_ff;
      s1_coff_ff  <= col_off_ff;
      s1_roff_ff  <= row_off_ff;
   end

   // trim against the panel edge
   always_comb begin
      x_end  = signed'({2'b00, s1_x_ff}) + 18'(s1_w_ff);
      y_end  = signed'({2'b00, s1_y_ff}) + 18'(s1_h_ff);
      w_over = x_end > signed'({10'd0, s1_pw_ff});
      h_over = y_end > signed'({10'd0, s1_ph_ff});
      w_trim = w_over ? signed'({10'd0, s1_pw_ff}) - signed'({2'b00, s1_x_ff})
                      : 18'(s1_w_ff);
      h_trim = h_over ? signed'({10'd0, s1_ph_ff}) - signed'({2'b00, s1_y_ff})
                      : 18'(s1_h_ff);
      q_push = s1_valid_ff && (w_trim > 18'sd0) && (h_trim > 18'sd0);

      // a non-empty window lies inside the panel, so low bytes are exact
      q_job.col_lo = s1_x_ff[7:0] + s1_coff_ff;
      q_job.col_hi = s1_x_ff[7:0] + w_trim[7:0] - 8'd1 + s1_coff_ff;
      q_job.row_lo = s1_y_ff[7:0] + s1_roff_ff;
      q_job.row_hi = s1_y_ff[7:0] + h_trim[7:0] - 8'd1 + s1_roff_ff;
      q_job.run_w  = w_trim[7:0];
      q_job.run_h  = h_trim[7:0];
      q_job.color  = s1_color_ff;
   end

endmodule

// ===== rtl/crfc_queue.sv =====
module crfc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  crfc_pkg::job_type          push_job,
   input  logic                       pop,
   output logic                       head_valid,
   output crfc_pkg::job_type          head_job,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   crfc_pkg::job_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_valid = count_ff != '0;
   assign head_job   = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// ===== rtl/crfc_back.sv =====
module crfc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  crfc_pkg::job_type  head_job,
   output logic               pop,
   output logic               rsp_strobe,
   output crfc_pkg::rsp_type  rsp_word
);

   typedef enum logic [3:0] {
      ST_COL_CMD, ST_COL_SH, ST_COL_SL, ST_COL_EH, ST_COL_EL,
      ST_ROW_CMD, ST_ROW_SH, ST_ROW_SL, ST_ROW_EH, ST_ROW_EL,
      ST_MEM_CMD, ST_RUN
   } step_type;

   step_type          step_ff, step_in;
   logic              active_ff, active_in;
   crfc_pkg::job_type job_ff, job_in;
   logic              strobe_ff, strobe_in;
   crfc_pkg::rsp_type rsp_ff, rsp_in;
   step_type          step_next;

   always_comb begin
      case (step_ff)
         ST_COL_CMD: step_next = ST_COL_SH;
         ST_COL_SH:  step_next = ST_COL_SL;
         ST_COL_SL:  step_next = ST_COL_EH;
         ST_COL_EH:  step_next = ST_COL_EL;
         ST_COL_EL:  step_next = ST_ROW_CMD;
         ST_ROW_CMD: step_next = ST_ROW_SH;
         ST_ROW_SH:  step_next = ST_ROW_SL;
         ST_ROW_SL:  step_next = ST_ROW_EH;
         ST_ROW_EH:  step_next = ST_ROW_EL;
         ST_ROW_EL:  step_next = ST_MEM_CMD;
         ST_MEM_CMD: step_next = ST_RUN;
         default:    step_next = ST_COL_CMD;
      endcase
   end

   always_comb begin
      // next window starts straight after the pixel run word
      pop       = head_valid && (!active_ff || step_ff == ST_RUN);
      active_in = active_ff;
      step_in   = step_ff;
      job_in    = job_ff;
      if (pop) begin
         active_in = 1'b1;
         step_in   = ST_COL_CMD;
         job_in    = head_job;
      end else if (active_ff) begin
         if (step_ff == ST_RUN) begin
            active_in = 1'b0;
         end else begin
            step_in = step_next;
         end
      end

      strobe_in         = active_ff;
      rsp_in            = '0;
      rsp_in.kind       = crfc_pkg::KIND_DATA;
      rsp_in.byte_value = crfc_pkg::ADDR_HIGH_BYTE;
      case (step_ff)
         ST_COL_CMD: begin
            rsp_in.kind       = crfc_pkg::KIND_CMD;
            rsp_in.byte_value = crfc_pkg::CMD_COLUMN_ADDR;
         end
         ST_COL_SL: rsp_in.byte_value = job_ff.col_lo;
         ST_COL_EL: rsp_in.byte_value = job_ff.col_hi;
         ST_ROW_CMD: begin
            rsp_in.kind       = crfc_pkg::KIND_CMD;
            rsp_in.byte_value = crfc_pkg::CMD_ROW_ADDR;
         end
         ST_ROW_SL: rsp_in.byte_value = job_ff.row_lo;
         ST_ROW_EL: rsp_in.byte_value = job_ff.row_hi;
         ST_MEM_CMD: begin
            rsp_in.kind       = crfc_pkg::KIND_CMD;
            rsp_in.byte_value = crfc_pkg::CMD_MEM_WRITE;
         end
         ST_RUN: begin
            rsp_in.kind       = crfc_pkg::KIND_RUN;
            rsp_in.byte_value = '0;
            rsp_in.run_color  = job_ff.color;
            rsp_in.run_count  = {8'd0, job_ff.run_w} * {8'd0, job_ff.run_h};
            rsp_in.last       = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         step_ff   <= ST_COL_CMD;
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         step_ff   <= step_in;
         active_ff <= active_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word   = rsp_ff;

endmodule

// ===== rtl/clipped_rect_fill_command_stream_top.sv =====
// Rectangle fill to LCD address-window command stream.
// Request: raise req_start with req_word (signed origin and extent, RGB565
// colour); the word is taken on a clock edge where req_busy is low.
// The rectangle is clipped to the panel; an empty result gives no words.
// Otherwise twelve rsp words follow, one per cycle, each shown for one cycle
// with rsp_strobe high: column command and four address bytes, row command
// and four bytes, memory-write command, then the pixel run (last set).
// A request passes the clamp stage and the job queue to the sequencer, whose
// rsp words are registered. Sustained rate is set by the single response port;
// requests are taken every cycle until queued jobs plus the word in the clamp
// stage reach QUEUE_DEPTH, then busy rises.
// Registers on csr_*: 0 panel width, 1 panel height, 2 column offset,
// 3 row offset; write only while idle. Each request uses the values current
// when it was taken.
// Reset (synchronous) empties queue and sequencer and restores the register
// defaults 128, 160, 0, 0. The receiver has no back-pressure.
module clipped_rect_fill_command_stream_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_start,
   output logic              req_busy,
   input  crfc_pkg::req_type req_word,
   output logic              rsp_strobe,
   output crfc_pkg::rsp_type rsp_word,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic              q_push, q_pop, q_valid;
   crfc_pkg::job_type q_job, q_head;
   logic [CW-1:0]     q_count;

   crfc_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_start (req_start),
      .req_busy  (req_busy),
      .req_word  (req_word),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   crfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_job),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (q_head),
      .count      (q_count)
   );

   crfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_job   (q_head),
      .pop        (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

`ifndef SYNTHESIS
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < CW'(QUEUE_DEPTH)))
      else $error("job queue overflow");

   a_last_is_run : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.last == (rsp_word.kind == crfc_pkg::KIND_RUN)))
      else $error("last flag not on pixel run");

   a_run_nonzero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.kind == crfc_pkg::KIND_RUN) |-> (rsp_word.run_count != 16'd0))
      else $error("empty pixel run emitted");

   a_run_after_memwr : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.kind == crfc_pkg::KIND_CMD
       && rsp_word.byte_value == crfc_pkg::CMD_MEM_WRITE)
      |=> (rsp_strobe && rsp_word.kind == crfc_pkg::KIND_RUN))
      else $error("pixel run does not follow memory write");
`endif

endmodule

// ===== verif/tb_clipped_rect_fill_command_stream_top.sv =====
`timescale 1ns / 100ps

module tb_clipped_rect_fill_command_stream_top;

   localparam int SETTLE_CYCLES = 24;
   localparam int STALL_LIMIT   = 2000;
   localparam int IDLE_PERCENT  = 27;
   localparam int SHOWN_ERRORS  = 10;

   // clipped window of one request; fixed marks a hand-written expectation
   typedef struct packed {
      logic        fixed;
      logic        empty;
      logic [7:0]  col_lo;
      logic [7:0]  col_hi;
      logic [7:0]  row_lo;
      logic [7:0]  row_hi;
      logic [15:0] count;
   } fill_window_type;

   typedef struct packed {
      crfc_pkg::req_type word;
      fill_window_type   window;
   } fill_row_type;

   localparam fill_window_type PREDICTED = '0;
   localparam fill_window_type NO_FILL   =
      fill_window_type'{fixed: 1'b1, empty: 1'b1, default: '0};

   logic              clock;
   logic              reset;
   logic              req_start;
   logic              req_busy;
   crfc_pkg::req_type req_word;
   logic              rsp_strobe;
   crfc_pkg::rsp_type rsp_word;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic [7:0]        csr_data;

   // register copy used for clipping
   int panel_w;
   int panel_h;
   int col_off;
   int row_off;

   crfc_pkg::rsp_type pending_words[$];
   fill_window_type   request_windows[$];
   fill_row_type      directed_rows[$];
   int                fail_count;
   int                stall_count;

   clipped_rect_fill_command_stream_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_busy   (req_busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic crfc_pkg::req_type fill_req(int x, int y, int w, int h, int colour);
      crfc_pkg::req_type r;
      r.origin_x   = 16'(x);
      r.origin_y   = 16'(y);
      r.extent_w   = 16'(w);
      r.extent_h   = 16'(h);
      r.fill_color = 16'(colour);
      return r;
   endfunction

   function automatic fill_window_type fixed_window(int clo, int chi, int rlo, int rhi,
                                                    int count);
      fill_window_type f;
      f.fixed  = 1'b1;
      f.empty  = 1'b0;
      f.col_lo = 8'(clo);
      f.col_hi = 8'(chi);
      f.row_lo = 8'(rlo);
      f.row_hi = 8'(rhi);
      f.count  = 16'(count);
      return f;
   endfunction

   // clip at full int width so origin plus extent never wraps
   function automatic fill_window_type clip_to_panel(crfc_pkg::req_type r);
      int x, y, w, h;
      fill_window_type f;
      x = $signed(r.origin_x);
      y = $signed(r.origin_y);
      w = $signed(r.extent_w);
      h = $signed(r.extent_h);
      f = '0;
      if (x < 0) begin
         w += x;
         x = 0;
      end
      if (y < 0) begin
         h += y;
         y = 0;
      end
      if (x + w > panel_w) w = panel_w - x;
      if (y + h > panel_h) h = panel_h - y;
      if (w <= 0 || h <= 0) begin
         f.empty = 1'b1;
         return f;
      end
      f.col_lo = 8'(x + col_off);
      f.col_hi = 8'(x + w - 1 + col_off);
      f.row_lo = 8'(y + row_off);
      f.row_hi = 8'(y + h - 1 + row_off);
      f.count  = 16'(w * h);
      return f;
   endfunction

   function automatic crfc_pkg::rsp_type stream_word(logic [1:0] kind, logic [7:0] value,
                                                     logic [15:0] colour,
                                                     logic [15:0] count, logic last);
      crfc_pkg::rsp_type s;
      s.kind       = kind;
      s.byte_value = value;
      s.run_color  = colour;
      s.run_count  = count;
      s.last       = last;
      return s;
   endfunction

   function automatic void push_address(logic [7:0] cmd, logic [7:0] lo, logic [7:0] hi);
      pending_words.push_back(stream_word(crfc_pkg::KIND_CMD, cmd, '0, '0, 1'b0));
      pending_words.push_back(stream_word(crfc_pkg::KIND_DATA, crfc_pkg::ADDR_HIGH_BYTE,
                                          '0, '0, 1'b0));
      pending_words.push_back(stream_word(crfc_pkg::KIND_DATA, lo, '0, '0, 1'b0));
      pending_words.push_back(stream_word(crfc_pkg::KIND_DATA, crfc_pkg::ADDR_HIGH_BYTE,
                                          '0, '0, 1'b0));
      pending_words.push_back(stream_word(crfc_pkg::KIND_DATA, hi, '0, '0, 1'b0));
   endfunction

   function automatic void queue_fill_words(fill_window_type f, logic [15:0] colour);
      if (f.empty) return;
      push_address(crfc_pkg::CMD_COLUMN_ADDR, f.col_lo, f.col_hi);
      push_address(crfc_pkg::CMD_ROW_ADDR, f.row_lo, f.row_hi);
      pending_words.push_back(stream_word(crfc_pkg::KIND_CMD, crfc_pkg::CMD_MEM_WRITE,
                                          '0, '0, 1'b0));
      pending_words.push_back(stream_word(crfc_pkg::KIND_RUN, '0, colour, f.count, 1'b1));
   endfunction

   function automatic logic [15:0] pick_extreme();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'hFFFF;
         2: return 16'h0000;
         3: return 16'h0001;
         4: return 16'h7FFF;
         default: return 16'(panel_w);
      endcase
   endfunction

   // mostly rectangles around the panel, some raw noise and extremes
   function automatic crfc_pkg::req_type random_fill();
      int mode;
      int span_x, span_y;
      crfc_pkg::req_type r;
      mode   = $urandom_range(0, 9);
      span_x = panel_w + 40;
      span_y = panel_h + 40;
      r.fill_color = 16'($urandom);
      if (mode < 7) begin
         r.origin_x = 16'(int'($urandom_range(0, span_x)) - 20);
         r.origin_y = 16'(int'($urandom_range(0, span_y)) - 20);
         r.extent_w = 16'(int'($urandom_range(0, span_x)) - 2);
         r.extent_h = 16'(int'($urandom_range(0, span_y)) - 2);
      end else if (mode < 9) begin
         r.origin_x = 16'($urandom);
         r.origin_y = 16'($urandom);
         r.extent_w = 16'($urandom);
         r.extent_h = 16'($urandom);
      end else begin
         r.origin_x = pick_extreme();
         r.origin_y = pick_extreme();
         r.extent_w = pick_extreme();
         r.extent_h = pick_extreme();
      end
      return r;
   endfunction

   task automatic send_fill(crfc_pkg::req_type w, fill_window_type f);
      request_windows.push_back(f);
      req_start <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_busy) @(posedge clock);
   endtask

   task automatic maybe_idle();
      if ($urandom_range(0, 99) < IDLE_PERCENT) begin
         req_start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   // empty requests may still sit in the clamp stage after the last word
   task automatic drain();
      req_start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, int value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= 8'(value);
      @(posedge clock);
   endtask

   task automatic configure(int w, int h, int co, int ro);
      write_reg(crfc_pkg::CSR_PANEL_WIDTH, w);
      write_reg(crfc_pkg::CSR_PANEL_HEIGHT, h);
      write_reg(crfc_pkg::CSR_COLUMN_OFFSET, co);
      write_reg(crfc_pkg::CSR_ROW_OFFSET, ro);
      csr_write <= 1'b0;
      panel_w = w & 255;
      panel_h = h & 255;
      col_off = co & 255;
      row_off = ro & 255;
   endtask

   always @(posedge clock) begin
      crfc_pkg::rsp_type want;
      fill_window_type   win;
      bit                moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_strobe) begin
            moved = 1'b1;
            if (pending_words.size() == 0) begin
               if (fail_count < SHOWN_ERRORS)
                  $display("unexpected word: kind %0d byte %02h colour %04h count %0d last %0b",
                           rsp_word.kind, rsp_word.byte_value, rsp_word.run_color,
                           rsp_word.run_count, rsp_word.last);
               fail_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_word.kind !== want.kind || rsp_word.byte_value !== want.byte_value ||
                   rsp_word.run_color !== want.run_color ||
                   rsp_word.run_count !== want.run_count || rsp_word.last !== want.last) begin
                  if (fail_count < SHOWN_ERRORS) begin
                     $display("mismatch: exp kind %0d byte %02h colour %04h count %0d last %0b",
                              want.kind, want.byte_value, want.run_color, want.run_count,
                              want.last);
                     $display("          got kind %0d byte %02h colour %04h count %0d last %0b",
                              rsp_word.kind, rsp_word.byte_value, rsp_word.run_color,
                              rsp_word.run_count, rsp_word.last);
                  end
                  fail_count++;
               end
            end
         end
         if (req_start && !req_busy) begin
            moved = 1'b1;
            win = request_windows.pop_front();
            if (!win.fixed) win = clip_to_panel(req_word);
            queue_fill_words(win, req_word.fill_color);
         end
         stall_count = moved ? 0 : stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("tb_clipped_rect_fill_command_stream_top: done, errors");
            $finish;
         end
      end
   end

   initial begin
      fill_row_type row;
      int           n_items;
      reset       = 1'b1;
      req_start   = 1'b0;
      req_word    = '0;
      csr_write   = 1'b0;
      csr_index   = crfc_pkg::CSR_PANEL_WIDTH;
      csr_data    = '0;
      panel_w     = 128;
      panel_h     = 160;
      col_off     = 0;
      row_off     = 0;
      fail_count  = 0;
      stall_count = 0;

      // reset registers: 128 x 160 panel, no offsets
      directed_rows.push_back(fill_row_type'{fill_req(0, 0, 1, 1, 'h0000),
                                             fixed_window(0, 0, 0, 0, 1)});
      directed_rows.push_back(fill_row_type'{fill_req(127, 159, 1, 1, 'hFFFF),
                                             fixed_window(127, 127, 159, 159, 1)});
      directed_rows.push_back(fill_row_type'{fill_req(0, 0, 128, 160, 'hF800),
                                             fixed_window(0, 127, 0, 159, 20480)});
      directed_rows.push_back(fill_row_type'{fill_req(0, 0, 32767, 32767, 'h07E0),
                                             fixed_window(0, 127, 0, 159, 20480)});
      directed_rows.push_back(fill_row_type'{fill_req(-32768, -32768, 32767, 32767, 'h001F),
                                             NO_FILL});
      // would wrap at 16 bits
      directed_rows.push_back(fill_row_type'{fill_req(-32768, -32768, -32768, -32768, 'hFFFF),
                                             NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(32767, 32767, 32767, 32767, 'h1234),
                                             NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(10, 10, 0, 5, 'h4321), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(10, 10, 5, 0, 'h4321), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(10, 10, -1, -32768, 'h8001), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(-5, -10, 10, 20, 'hA5A5),
                                             fixed_window(0, 4, 0, 9, 50)});
      directed_rows.push_back(fill_row_type'{fill_req(-1, 3, 1, 1, 'h0F0F), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(128, 0, 10, 10, 'h00FF), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(0, 160, 10, 10, 'hFF00), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(120, 150, 100, 100, 'h5A5A),
                                             fixed_window(120, 127, 150, 159, 80)});
      directed_rows.push_back(fill_row_type'{fill_req(127, 0, 2, 160, 'hCAFE),
                                             fixed_window(127, 127, 0, 159, 160)});
      directed_rows.push_back(fill_row_type'{fill_req(30, 40, -32768, 10, 'h7FFF), NO_FILL});
      directed_rows.push_back(fill_row_type'{fill_req(-100, 20, 150, 40, 'h0F0F),
                                             PREDICTED});
      directed_rows.push_back(fill_row_type'{fill_req(50, -32768, 20, 32767, 'hF0F0),
                                             PREDICTED});
      directed_rows.push_back(fill_row_type'{fill_req(-20000, 0, 20010, 1, 'h3C3C),
                                             PREDICTED});
      directed_rows.push_back(fill_row_type'{fill_req(64, 80, 3, 7, 'hC3C3), PREDICTED});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_fill(row.word, row.window);
         maybe_idle();
      end

      for (int phase = 0; phase < 7; phase++) begin
         drain();
         case (phase)
            0: configure(255, 255, 255, 128);   // offsets wrap the address bytes
            1: configure(1, 1, 0, 0);
            2: configure(0, 90, 17, 33);        // zero width, nothing drawn
            3: configure(200, 0, 1, 2);         // zero height, nothing drawn
            default: configure($urandom_range(1, 255), $urandom_range(1, 255),
                               $urandom_range(0, 255), $urandom_range(0, 255));
         endcase
         n_items = (phase == 2 || phase == 3) ? 15 : 60;
         for (int i = 0; i < n_items; i++) begin
            send_fill(random_fill(), PREDICTED);
            // phase 4 runs flat out
            if (phase != 4) maybe_idle();
         end
      end
      drain();

      if (fail_count == 0 && pending_words.size() == 0) begin
         $display("tb_clipped_rect_fill_command_stream_top: done, clean");
      end else begin
         $display("tb_clipped_rect_fill_command_stream_top: done, errors");
      end
      $finish;
   end

endmodule
